@@ rtl/core/mqdf_pkg.sv @@
// Shared types and constants for the multi-queue descriptor FIFO.
// No dependencies; used by the channel interfaces and the top level.
package mqdf_pkg;

  // Width of the queue select field on the command channel
  localparam int unsigned QSEL_BITS = 4;

  // Operation carried by a command transaction
  typedef enum logic [0:0] {
    CMD_ENQ = 1'b0,
    CMD_DEQ = 1'b1
  } cmd_t;

endpackage

@@ rtl/core/mqdf_if.sv @@
// Valid/ready channel interfaces for the multi-queue descriptor FIFO.
// Depends on mqdf_pkg for the command type and queue select width.

// Command channel: one enqueue or dequeue per transaction
interface mqdf_cmd_if #(
  parameter int unsigned HANDLE_BITS = 32
);
  logic                            valid;
  logic                            ready;
  mqdf_pkg::cmd_t                  command;
  logic [mqdf_pkg::QSEL_BITS-1:0]  queue;
  logic [HANDLE_BITS-1:0]          handle_in;

  modport source (output valid, command, queue, handle_in, input ready);
  modport sink   (input valid, command, queue, handle_in, output ready);
endinterface

// Response channel: one result per command
interface mqdf_rsp_if #(
  parameter int unsigned HANDLE_BITS = 32
);
  logic                   valid;
  logic                   ready;
  logic                   ok;
  logic [HANDLE_BITS-1:0] handle_out;
  logic                   now_empty;

  modport source (output valid, ok, handle_out, now_empty, input ready);
  modport sink   (input valid, ok, handle_out, now_empty, output ready);
endinterface

@@ rtl/core/mqdf_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module mqdf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned WORDS = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(WORDS)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(WORDS)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [WORDS];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/multi_queue_descriptor_fifo.sv @@
// Multi-queue descriptor FIFO top level: per-queue pointer state and handle slots in RAM.
// Depends on mqdf_pkg, mqdf_cmd_if / mqdf_rsp_if and mqdf_ram.
//
//   channel | dir | transaction carries
//   --------+-----+------------------------------------------
//   cmd     | in  | command, queue, handle_in
//   rsp     | out | ok, handle_out, now_empty
//
// One command in flight at a time: accept, pointer lookup, result. A command is
// accepted in ST_IDLE, looked up in ST_LOOKUP, and ST_DONE loads the result
// register once it is free; only then is the next command taken. The order is set
// by the read-modify-write of the queue-state RAM followed by the slot RAM read.
// Reset is synchronous; queue state reads as empty until a queue is first written.
// The result register holds while rsp.ready is low; the command side waits then.
module multi_queue_descriptor_fifo #(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned DEPTH       = 8,
  parameter int unsigned HANDLE_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  mqdf_cmd_if.sink  cmd,
  mqdf_rsp_if.source rsp
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned QW = $clog2(NUM_QUEUES);
  localparam int unsigned SLOTS = NUM_QUEUES * DEPTH;
  localparam int unsigned AW = $clog2(SLOTS);
  localparam int unsigned QX = (QW > mqdf_pkg::QSEL_BITS) ? QW : mqdf_pkg::QSEL_BITS;
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);

  // Per-queue state word
  typedef struct packed {
    logic          empty;
    logic [PW-1:0] wr;
    logic [PW-1:0] rd;
  } qstate_t;

  localparam int unsigned QSW = $bits(qstate_t);
  localparam qstate_t QSTATE_RESET = '{empty: 1'b1, wr: PTR_LAST, rd: PTR_LAST};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DONE
  } state_t;

  state_t                 state;
  mqdf_pkg::cmd_t         cur_cmd;
  logic [QW-1:0]          cur_q;
  logic                   cur_in_range;
  logic [HANDLE_BITS-1:0] cur_handle;
  logic                   res_ok;
  logic                   res_empty;
  logic                   res_deq;
  logic [NUM_QUEUES-1:0]  qvalid;

  logic                   out_valid;
  logic                   out_ok;
  logic [HANDLE_BITS-1:0] out_handle;
  logic                   out_empty;

  logic                   accept;
  logic                   out_free;
  logic [QX-1:0]          qext;
  logic [QW-1:0]          qidx;
  logic                   in_range;

  logic                   qs_re;
  logic [QSW-1:0]         qs_rdata;
  logic                   qs_we;
  qstate_t                qs_wdata;
  qstate_t                qs;

  logic                   slot_we;
  logic                   slot_re;
  logic [AW-1:0]          slot_addr;
  logic [HANDLE_BITS-1:0] slot_rdata;

  logic                   full;
  logic [PW-1:0]          wnext;
  logic [PW-1:0]          rnext;
  logic [PW-1:0]          slot_ptr;
  logic                   res_ok_next;
  logic                   res_empty_next;
  logic                   res_deq_next;

  // Handshake and queue select decode
  assign accept   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == ST_IDLE);
  assign out_free = !out_valid || rsp.ready;
  assign qext     = QX'(cmd.queue);
  assign qidx     = qext[QW-1:0];
  assign in_range = (32'(cmd.queue) < NUM_QUEUES);

  // Queue-state RAM: read on accept, written back in lookup
  assign qs_re = accept;

  mqdf_ram #(
    .WIDTH (QSW),
    .WORDS (NUM_QUEUES)
  ) u_qstate_ram (
    .clk   (clk),
    .we    (qs_we),
    .waddr (cur_q),
    .wdata (qs_wdata),
    .re    (qs_re),
    .raddr (qidx),
    .rdata (qs_rdata)
  );

  // Handle slot RAM, one row of DEPTH slots per queue
  mqdf_ram #(
    .WIDTH (HANDLE_BITS),
    .WORDS (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_addr),
    .wdata (cur_handle),
    .re    (slot_re),
    .raddr (slot_addr),
    .rdata (slot_rdata)
  );

  // Lookup: pointer update, full/empty decisions
  always_comb begin
    qs = qvalid[cur_q] ? qstate_t'(qs_rdata) : QSTATE_RESET;
    full  = (qs.wr == qs.rd) && !qs.empty;
    wnext = (qs.wr == PTR_LAST) ? '0 : qs.wr + PW'(1);
    rnext = (qs.rd == PTR_LAST) ? '0 : qs.rd + PW'(1);

    qs_we          = 1'b0;
    qs_wdata       = qs;
    slot_we        = 1'b0;
    slot_re        = 1'b0;
    slot_ptr       = wnext;
    res_ok_next    = 1'b0;
    res_empty_next = 1'b1;
    res_deq_next   = 1'b0;

    if (state == ST_LOOKUP && cur_in_range) begin
      unique case (cur_cmd)
        mqdf_pkg::CMD_ENQ: begin
          res_empty_next = qs.empty;
          if (!full) begin
            qs_we          = 1'b1;
            qs_wdata       = '{empty: 1'b0, wr: wnext, rd: qs.rd};
            slot_we        = 1'b1;
            res_ok_next    = 1'b1;
            res_empty_next = 1'b0;
          end
        end
        mqdf_pkg::CMD_DEQ: begin
          slot_ptr = rnext;
          if (!qs.empty) begin
            qs_we          = 1'b1;
            qs_wdata       = '{empty: (rnext == qs.wr), wr: qs.wr, rd: rnext};
            slot_re        = 1'b1;
            res_ok_next    = 1'b1;
            res_empty_next = (rnext == qs.wr);
            res_deq_next   = 1'b1;
          end
        end
        default: begin
          res_ok_next = 1'b0;
        end
      endcase
    end

    slot_addr = AW'(cur_q) * AW'(DEPTH) + AW'(slot_ptr);
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      qvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      // New result loads when the register is free; otherwise drop on accept
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (qs_we) begin
        qvalid[cur_q] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_LOOKUP;
          end
        end
        ST_LOOKUP: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_cmd      <= cmd.command;
      cur_q        <= qidx;
      cur_in_range <= in_range;
      cur_handle   <= cmd.handle_in;
    end
    if (state == ST_LOOKUP) begin
      res_ok    <= res_ok_next;
      res_empty <= res_empty_next;
      res_deq   <= res_deq_next;
    end
    if (state == ST_DONE && out_free) begin
      out_ok     <= res_ok;
      out_empty  <= res_empty;
      out_handle <= res_deq ? slot_rdata : '0;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.ok         = out_ok;
  assign rsp.handle_out = out_handle;
  assign rsp.now_empty  = out_empty;

  // Slot RAM never written and read in the same cycle
  a_slot_port_excl: assert property (@(posedge clk) disable iff (rst)
    !(slot_we && slot_re))
    else $error("slot RAM written and read in the same cycle");

  // A slot read is followed by the result stage in the cycle after the read
  a_slot_read_done: assert property (@(posedge clk) disable iff (rst)
    slot_re |=> (state == ST_DONE))
    else $error("slot read not followed by result stage");

  // A new result only comes out of the result stage
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result raised outside result stage");

endmodule
